// ----- hw/rtl/jpeg_colour_to_rgb_top_defines.svh -----
// Assertion macros for the colour converter top level.
// Taken in by `include; needs nothing else.
`ifndef JPEG_COLOUR_TO_RGB_TOP_DEFINES_SVH
`define JPEG_COLOUR_TO_RGB_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define JC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colour converter check failed");

// Next-cycle implication, disabled while reset is low.
`define JC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colour converter check failed");

`endif

// ----- hw/rtl/jc2rgb_pkg.sv -----
// Types, constants and per-channel helper functions for the colour converter.
// No dependencies.
package jc2rgb_pkg;

    localparam int QW   = 27;
    localparam int NUMW = 36;

    typedef logic signed [QW-1:0]   t_q;
    typedef logic signed [NUMW-1:0] t_num;
    typedef logic [1:0]             t_mode;

    localparam t_mode MODE_GRAY  = 2'd0;
    localparam t_mode MODE_YCC   = 2'd1;
    localparam t_mode MODE_YCCK  = 2'd2;
    localparam t_mode MODE_RESET = MODE_YCC;

    localparam logic REG_COLOUR_MODE = 1'b0;

    localparam t_q COEF_CR_R  = 27'sd91881;
    localparam t_q COEF_CB_G  = 27'sd22554;
    localparam t_q COEF_CR_G  = 27'sd46802;
    localparam t_q COEF_CB_B  = 27'sd116130;
    localparam t_q FULL_SCALE = 27'sd16711680;

    localparam logic [16:0] SAT_LIMIT = 17'd65280;

    // Q16 value to byte: drop fraction, saturate at 0 and 255.
    function automatic logic [7:0] clamp_q16(input t_q v);
        logic [7:0] res;
        res = 8'd0;
        if (v <= 0) begin
            res = 8'd0;
        end else if (v[QW-2:24] != '0) begin
            res = 8'd255;
        end else begin
            res = v[23:16];
        end
        return res;
    endfunction

    // (255*2^16 - X) * K / (255*2^16): shift by 16, then divide by 255.
    function automatic logic [7:0] ycck_div(input t_num num);
        logic [16:0] t;
        logic [15:0] s;
        logic [7:0]  res;
        t   = num[32:16];
        s   = t[15:0] + 16'(t[15:8]) + 16'd1;
        res = 8'd0;
        if (num <= 0) begin
            res = 8'd0;
        end else if (t >= SAT_LIMIT) begin
            res = 8'd255;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/jpeg_colour_to_rgb_top.sv -----
// Colour converter top level: four-stage pipeline from Y/Cb/Cr/K samples to RGB.
// Depends on jc2rgb_pkg and jpeg_colour_to_rgb_top_defines.svh.
//
// Usage:
//   Input channel: i_valid / o_stall carry one pixel's samples per beat
//   (i_luma, i_chroma_blue, i_chroma_red, i_black_level). A beat is taken
//   at a rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry one RGB beat (o_red, o_green,
//   o_blue) per input beat, in order.
//   APB port: one register, colour_mode at byte address 0 (0 gray copy,
//   1 YCbCr, 2 YCCK, 3 treated as YCbCr). Write it only while idle.
//   Path: a taken beat moves through stages A, B, C and D in order.
//   Throughput: one pixel per cycle unless i_stall holds the output; the
//   constant multiplies, the Q16 sums, the 27x9 K multiply and the
//   divide-by-255 each own one stage.
//   Reset (synchronous, active low) empties the pipeline and sets
//   colour_mode to YCbCr.
//   When the receiver stalls, the output beat holds; earlier stages keep
//   filling bubbles, and o_stall rises only once all four stages are full.
`include "jpeg_colour_to_rgb_top_defines.svh"

module jpeg_colour_to_rgb_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_luma,
    input  logic [7:0]  i_chroma_blue,
    input  logic [7:0]  i_chroma_red,
    input  logic [7:0]  i_black_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    jc2rgb_pkg::t_mode r_mode;

    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic w_en_a, w_en_b, w_en_c, w_en_d;
    logic w_in_acc, w_out_acc;
    logic [3:0] w_occ;

    // stage A: constant products
    jc2rgb_pkg::t_q    r_a_pr, r_a_pgb, r_a_pgr, r_a_pb;
    logic [7:0]        r_a_y, r_a_k;
    jc2rgb_pkg::t_mode r_a_mode;
    jc2rgb_pkg::t_q    n_a_pr, n_a_pgb, n_a_pgr, n_a_pb;
    logic signed [8:0] w_cb, w_cr;

    // stage B: Q16 channel values
    jc2rgb_pkg::t_q    r_b_rq, r_b_gq, r_b_bq;
    logic [7:0]        r_b_y, r_b_k;
    jc2rgb_pkg::t_mode r_b_mode;
    jc2rgb_pkg::t_q    n_b_rq, n_b_gq, n_b_bq, w_y_q16;

    // stage C: clamped YCbCr bytes and YCCK products
    logic [7:0]         r_c_rc, r_c_gc, r_c_bc, r_c_y;
    jc2rgb_pkg::t_num   r_c_rn, r_c_gn, r_c_bn;
    jc2rgb_pkg::t_mode  r_c_mode;
    jc2rgb_pkg::t_num   n_c_rn, n_c_gn, n_c_bn;
    logic signed [8:0]  w_k_s;

    // stage D: output beat
    logic [7:0]        r_red, r_green, r_blue;
    jc2rgb_pkg::t_mode r_d_mode;
    logic [7:0]        n_red, n_green, n_blue;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == jc2rgb_pkg::REG_COLOUR_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jc2rgb_pkg::MODE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == jc2rgb_pkg::REG_COLOUR_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign w_en_d    = !r_d_valid || !i_stall;
    assign w_en_c    = !r_c_valid || w_en_d;
    assign w_en_b    = !r_b_valid || w_en_c;
    assign w_en_a    = !r_a_valid || w_en_b;
    assign o_stall   = !w_en_a;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = o_valid && !i_stall;
    assign w_occ     = {r_a_valid, r_b_valid, r_c_valid, r_d_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_en_a) begin
                r_a_valid <= i_valid;
            end
            if (w_en_b) begin
                r_b_valid <= r_a_valid;
            end
            if (w_en_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_en_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_comb begin
        w_cb    = $signed({1'b0, i_chroma_blue}) - 9'sd128;
        w_cr    = $signed({1'b0, i_chroma_red}) - 9'sd128;
        n_a_pr  = jc2rgb_pkg::t_q'(w_cr) * jc2rgb_pkg::COEF_CR_R;
        n_a_pgb = jc2rgb_pkg::t_q'(w_cb) * jc2rgb_pkg::COEF_CB_G;
        n_a_pgr = jc2rgb_pkg::t_q'(w_cr) * jc2rgb_pkg::COEF_CR_G;
        n_a_pb  = jc2rgb_pkg::t_q'(w_cb) * jc2rgb_pkg::COEF_CB_B;
    end

    always_comb begin
        w_y_q16 = $signed(jc2rgb_pkg::QW'({r_a_y, 16'h0000}));
        n_b_rq  = w_y_q16 + r_a_pr;
        n_b_gq  = w_y_q16 - r_a_pgb - r_a_pgr;
        n_b_bq  = w_y_q16 + r_a_pb;
    end

    always_comb begin
        w_k_s  = $signed({1'b0, r_b_k});
        n_c_rn = jc2rgb_pkg::t_num'(jc2rgb_pkg::FULL_SCALE - r_b_rq)
                 * jc2rgb_pkg::t_num'(w_k_s);
        n_c_gn = jc2rgb_pkg::t_num'(jc2rgb_pkg::FULL_SCALE - r_b_gq)
                 * jc2rgb_pkg::t_num'(w_k_s);
        n_c_bn = jc2rgb_pkg::t_num'(jc2rgb_pkg::FULL_SCALE - r_b_bq)
                 * jc2rgb_pkg::t_num'(w_k_s);
    end

    always_comb begin
        case (r_c_mode)
            jc2rgb_pkg::MODE_GRAY: begin
                n_red   = r_c_y;
                n_green = r_c_y;
                n_blue  = r_c_y;
            end
            jc2rgb_pkg::MODE_YCCK: begin
                n_red   = jc2rgb_pkg::ycck_div(r_c_rn);
                n_green = jc2rgb_pkg::ycck_div(r_c_gn);
                n_blue  = jc2rgb_pkg::ycck_div(r_c_bn);
            end
            default: begin
                n_red   = r_c_rc;
                n_green = r_c_gc;
                n_blue  = r_c_bc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            r_a_pr   <= n_a_pr;
            r_a_pgb  <= n_a_pgb;
            r_a_pgr  <= n_a_pgr;
            r_a_pb   <= n_a_pb;
            r_a_y    <= i_luma;
            r_a_k    <= i_black_level;
            r_a_mode <= r_mode;
        end
        if (w_en_b) begin
            r_b_rq   <= n_b_rq;
            r_b_gq   <= n_b_gq;
            r_b_bq   <= n_b_bq;
            r_b_y    <= r_a_y;
            r_b_k    <= r_a_k;
            r_b_mode <= r_a_mode;
        end
        if (w_en_c) begin
            r_c_rc   <= jc2rgb_pkg::clamp_q16(r_b_rq);
            r_c_gc   <= jc2rgb_pkg::clamp_q16(r_b_gq);
            r_c_bc   <= jc2rgb_pkg::clamp_q16(r_b_bq);
            r_c_rn   <= n_c_rn;
            r_c_gn   <= n_c_gn;
            r_c_bn   <= n_c_bn;
            r_c_y    <= r_b_y;
            r_c_mode <= r_b_mode;
        end
        if (w_en_d) begin
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_d_mode <= r_c_mode;
        end
    end

    assign o_valid = r_d_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    `JC_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, w_occ == 4'hF && i_stall)
    `JC_ASSERT_NEXT(a_count_kept, i_clk, i_rst_n, !w_in_acc && !w_out_acc, $countones(w_occ) == $past($countones(w_occ)))
    `JC_ASSERT_NOW(a_gray_equal, i_clk, i_rst_n, o_valid && r_d_mode == jc2rgb_pkg::MODE_GRAY, o_red == o_green && o_green == o_blue)

endmodule
